// File: hw/rtl/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// shared widths, opcodes and the command record passed from front to back
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 6;
    localparam int OPCODE_W    = 3;
    localparam int IN_DATA_W   = 40;   // value + bit_count, padded to bytes
    localparam int BYTE_W      = 8;
    localparam int QUOT_W      = 8;
    localparam int TOTAL_W     = 9;    // up to 63 + 255 + 1 stream bits
    localparam int MAX_BYTES   = 5;    // longest aligned run (varint)
    localparam int NBYTES_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [QUOT_W-1:0] MAX_QUOTIENT = 8'd255;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OP_FIXED  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_UNARY  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_RICE   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_BYTE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SHORT  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_VARINT = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_FLUSH  = 3'd6;

    // command kinds
    localparam logic [1:0] CMD_BITS  = 2'd0;
    localparam logic [1:0] CMD_ALIGN = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;

    // bit stream of a BITS command: k bits of value, q ones, then zeros up to total
    typedef struct packed {
        logic [1:0]                        kind;
        logic [VALUE_W-1:0]                value;
        logic [COUNT_W-1:0]                k;
        logic [QUOT_W-1:0]                 q;
        logic [TOTAL_W-1:0]                total;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]  bytes;
        logic [NBYTES_W-1:0]               nbytes;
    } cmd_t;

endpackage

// File: hw/rtl/rbp_front.sv
// ----------------------------------------------------------------------------
// rbp_front
// decodes an input transaction into a bit-stream, aligned-byte or error command
// ----------------------------------------------------------------------------
module rbp_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rbp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [rbp_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output rbp_pkg::cmd_t                  push_cmd
);
    import rbp_pkg::*;

    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  bit_count;
    logic [VALUE_W-1:0]  quot;
    logic [NBYTES_W-1:0] groups_used;
    logic [6:0]          grp [0:7];
    logic                keep;
    logic                too_big;
    cmd_t                cmd;

    always_comb
    begin
        value     = s_tdata[VALUE_W-1:0];
        bit_count = s_tdata[VALUE_W+COUNT_W-1:VALUE_W];
        quot      = (bit_count < 6'd32) ? (value >> bit_count[4:0]) : '0;

        grp[0] = value[6:0];
        grp[1] = value[13:7];
        grp[2] = value[20:14];
        grp[3] = value[27:21];
        grp[4] = {3'b000, value[31:28]};
        grp[5] = '0;
        grp[6] = '0;
        grp[7] = '0;

        if (value[31:28] != '0)
            groups_used = 3'd5;
        else if (value[27:21] != '0)
            groups_used = 3'd4;
        else if (value[20:14] != '0)
            groups_used = 3'd3;
        else if (value[13:7] != '0)
            groups_used = 3'd2;
        else
            groups_used = 3'd1;

        cmd     = '0;
        keep    = 1'b1;
        too_big = 1'b0;
        case (s_tuser)
            OP_FIXED:
            begin
                cmd.kind  = CMD_BITS;
                cmd.value = value;
                cmd.k     = bit_count;
                cmd.total = {3'b000, bit_count};
                keep      = (bit_count != '0);
            end
            OP_UNARY:
            begin
                too_big   = (value > {24'd0, MAX_QUOTIENT});
                cmd.kind  = too_big ? CMD_ERROR : CMD_BITS;
                cmd.q     = value[QUOT_W-1:0];
                cmd.total = {1'b0, value[QUOT_W-1:0]} + 9'd1;
            end
            OP_RICE:
            begin
                too_big   = (quot > {24'd0, MAX_QUOTIENT});
                cmd.kind  = too_big ? CMD_ERROR : CMD_BITS;
                cmd.value = value;
                cmd.k     = bit_count;
                cmd.q     = quot[QUOT_W-1:0];
                cmd.total = {3'b000, bit_count} + {1'b0, quot[QUOT_W-1:0]} + 9'd1;
            end
            OP_BYTE:
            begin
                cmd.kind     = CMD_ALIGN;
                cmd.bytes[0] = value[7:0];
                cmd.nbytes   = 3'd1;
            end
            OP_SHORT:
            begin
                cmd.kind     = CMD_ALIGN;
                cmd.bytes[0] = value[15:8];
                cmd.bytes[1] = value[7:0];
                cmd.nbytes   = 3'd2;
            end
            OP_VARINT:
            begin
                cmd.kind   = CMD_ALIGN;
                cmd.nbytes = groups_used;
                // highest nonzero group first, continuation on all but the last
                for (int i = 0; i < MAX_BYTES; i++)
                begin
                    if (3'(i) < groups_used)
                        cmd.bytes[i] = {(3'(i) != groups_used - 3'd1),
                                        grp[3'(groups_used - 3'(i) - 3'd1)]};
                end
            end
            OP_FLUSH:
            begin
                cmd.kind   = CMD_ALIGN;
                cmd.nbytes = '0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped items are taken without a push
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && keep;
    assign push_cmd   = cmd;

endmodule

// File: hw/rtl/rbp_queue.sv
// ----------------------------------------------------------------------------
// rbp_queue
// two-entry command queue between the decode front and the packing back
// ----------------------------------------------------------------------------
module rbp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rbp_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rbp_pkg::cmd_t rd_cmd
);
    import rbp_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// File: hw/rtl/rbp_back.sv
// ----------------------------------------------------------------------------
// rbp_back
// runs queued commands against the partial byte and drives the output register
// ----------------------------------------------------------------------------
module rbp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  rbp_pkg::cmd_t               q_cmd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rbp_pkg::BYTE_W-1:0]  m_tdata,
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast
);
    import rbp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_BITS  = 3'd2;
    localparam logic [2:0] ST_BYTES = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [TOTAL_W-1:0]  off_reg, off_next;
    logic [NBYTES_W-1:0] idx_reg, idx_next;
    logic [BYTE_W-1:0]   partial_reg, partial_next;
    logic [2:0]          bitpos_reg, bitpos_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_error_reg, out_error_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic [3:0]          space;
    logic [TOTAL_W-1:0]  remain;
    logic [3:0]          n;
    logic [VALUE_W-1:0]  shifted;
    logic [9:0]          ones_end;
    logic [9:0]          lane_pos [0:7];
    logic [7:0]          chunk;
    logic [8:0]          mask;
    logic [BYTE_W-1:0]   merged;
    logic [TOTAL_W-1:0]  off_sum;
    logic                full;
    logic                last_byte;

    assign out_free = !out_valid_reg || m_tready;

    // up to one byte's worth of stream bits per cycle, while the output register is free
    always_comb
    begin
        space    = 4'd8 - {1'b0, bitpos_reg};
        remain   = cmd_reg.total - off_reg;
        n        = (remain < {5'b0, space}) ? remain[3:0] : space;
        shifted  = (off_reg < 9'd32) ? (cmd_reg.value >> off_reg[4:0]) : '0;
        ones_end = {4'b0, cmd_reg.k} + {2'b0, cmd_reg.q};
        for (int j = 0; j < 8; j++)
        begin
            lane_pos[j] = {1'b0, off_reg} + 10'(j);
            chunk[j]    = (lane_pos[j] < {4'b0, cmd_reg.k}) ? shifted[j]
                                                            : (lane_pos[j] < ones_end);
        end
        mask    = (9'd1 << n) - 9'd1;
        merged  = partial_reg | ((chunk & mask[7:0]) << bitpos_reg);
        off_sum = off_reg + {5'b0, n};
        full    = (n == space);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        partial_next   = partial_reg;
        bitpos_next    = bitpos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_error_next = out_error_reg;
        out_last_next  = out_last_reg;
        q_ready        = 1'b0;
        last_byte      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    off_next = '0;
                    idx_next = '0;
                    case (q_cmd.kind)
                        CMD_BITS:  state_next = ST_BITS;
                        CMD_ALIGN: state_next = ST_PAD;
                        default:   state_next = ST_ERR;
                    endcase
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    if (bitpos_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = partial_reg;
                        out_error_next = 1'b0;
                        out_last_next  = (cmd_reg.nbytes == '0);
                    end
                    partial_next = '0;
                    bitpos_next  = '0;
                    state_next   = (cmd_reg.nbytes == '0) ? ST_IDLE : ST_BYTES;
                end
            end
            ST_BITS:
            begin
                if (out_free)
                begin
                    if (full)
                    begin
                        // no later byte closes when fewer than eight bits remain
                        out_valid_next = 1'b1;
                        out_byte_next  = merged;
                        out_error_next = 1'b0;
                        out_last_next  = ((cmd_reg.total - off_sum) < 9'd8);
                        partial_next   = '0;
                        bitpos_next    = '0;
                    end
                    else
                    begin
                        partial_next = merged;
                        bitpos_next  = bitpos_reg + n[2:0];
                    end
                    off_next = off_sum;
                    if (off_sum == cmd_reg.total)
                        state_next = ST_IDLE;
                end
            end
            ST_BYTES:
            begin
                if (out_free)
                begin
                    last_byte      = (idx_reg == cmd_reg.nbytes - 3'd1);
                    out_valid_next = 1'b1;
                    out_byte_next  = cmd_reg.bytes[idx_reg];
                    out_error_next = 1'b0;
                    out_last_next  = last_byte;
                    idx_next       = idx_reg + 3'd1;
                    if (last_byte)
                        state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_error_next = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            off_reg       <= '0;
            idx_reg       <= '0;
            partial_reg   <= '0;
            bitpos_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            off_reg       <= off_next;
            idx_reg       <= idx_next;
            partial_reg   <= partial_next;
            bitpos_reg    <= bitpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_byte_reg  <= out_byte_next;
        out_error_reg <= out_error_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_error_reg;
    assign m_tlast    = out_last_reg;

endmodule

// File: hw/rtl/rice_bit_packer.sv
// ----------------------------------------------------------------------------
// rice_bit_packer
// packs fixed, unary, rice, byte, short and varint codes into an lsb-first
// byte stream
// ----------------------------------------------------------------------------
// usage
//   slave side: one transaction per code; tuser carries the opcode, tdata the
//   value (bits 31:0) and bit_count (bits 37:32)
//   master side: one transaction per finished byte; tuser flags a dropped
//   item (quotient over the limit), tlast marks the last byte of an item
//   items that close no byte give no master transaction at all
// an item's first byte passes the queue write, dispatch and the output register
//   before it shows on the master side; an aligned item with no open byte also
//   passes its empty pad step first
// the back end dispatches each item, then works a bit code in steps of up to one
//   byte of stream bits, an error in a single step, or an aligned item as a pad
//   step plus one step per aligned byte; it takes no new item until it is back in
//   idle, and each step waits until its single output register is free
// the two-entry command queue lets new items enter while the back end works
//   or while the receiver stalls; tready drops only once the queue is full
// reset clears the open partial byte, the queue and the output register
// ----------------------------------------------------------------------------
module rice_bit_packer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rbp_pkg::IN_DATA_W-1:0]  s_tdata,   // value[31:0], bit_count[37:32]
    input  logic [rbp_pkg::OPCODE_W-1:0]   s_tuser,   // opcode[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rbp_pkg::BYTE_W-1:0]     m_tdata,   // out_byte[7:0]
    output logic [0:0]                     m_tuser,   // error[0]
    output logic                           m_tlast    // last_of_run
);
    import rbp_pkg::*;

    // front to queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue to back
    logic q_rd_valid;
    logic q_rd_ready;
    cmd_t q_rd_cmd;

    // decode: error check on the quotient, varint groups, drops of empty items and unknown opcodes
    rbp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decouples decode from packing so either side can stall alone
    rbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_cmd   (push_cmd),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_cmd   (q_rd_cmd)
    );

    // packing: holds the partial byte and the output register
    rbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_rd_valid),
        .q_ready  (q_rd_ready),
        .q_cmd    (q_rd_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // an error transaction is a single zero byte that ends its item
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
        else $error("error transaction not a lone zero byte");

    // the slave side only stalls behind a queue that holds commands
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_rd_valid)
        else $error("slave stalled with an empty command queue");

    // after a push the queue holds a command for the back end next cycle
    a_push_reaches_back: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |=> q_rd_valid)
        else $error("pushed command missing from queue");

endmodule
